/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the rtl, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* rtl/mtg_pkg.sv */
// ----------------------------------------------------------------------------
// mtg_pkg
// Types and constants of the midi clock tempo generator
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int BAR_SLOTS_DEF    = 16;
  localparam int TICKS_PER_EIGHTH = 12;

  localparam logic [15:0] INIT_PERIOD = 16'd250;
  localparam logic [4:0]  INIT_AMOUNT = 5'd4;
  localparam logic [3:0]  INIT_SMOOTH = 4'd4;

  // request codes
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_SYNC  = 3'd1;
  localparam logic [2:0] REQ_TEMPO = 3'd2;
  localparam logic [2:0] REQ_START = 3'd3;
  localparam logic [2:0] REQ_STOP  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_INIT_PERIOD = 2'd0;
  localparam logic [1:0] CFG_LAT_AMOUNT  = 2'd1;
  localparam logic [1:0] CFG_LAT_SMOOTH  = 2'd2;

  // midi messages
  localparam logic [7:0] MSG_CLOCK = 8'd248;
  localparam logic [7:0] MSG_START = 8'd250;
  localparam logic [7:0] MSG_STOP  = 8'd252;

  // onset gate codes
  localparam logic [1:0] GATE_NONE     = 2'd0;
  localparam logic [1:0] GATE_ALLOW    = 2'd1;
  localparam logic [1:0] GATE_DISALLOW = 2'd2;
  localparam logic [1:0] GATE_SYNC     = 2'd3;

  // tick phases with an action
  localparam logic [3:0] PH_EIGHTH    = 4'd0;
  localparam logic [3:0] PH_LED_OFF   = 4'd1;
  localparam logic [3:0] PH_GATE_SYNC = 4'd4;
  localparam logic [3:0] PH_HALF      = 4'd6;
  localparam logic [3:0] PH_GATE_OPEN = 4'd8;

  // reciprocals: x/3 for x < 2^17, x/5 for x < 2^18
  localparam logic [15:0] RECIP3 = 16'd43691;
  localparam logic [17:0] RECIP5 = 18'd209716;

  localparam logic [1:0] LAYER_TABLE [16] = '{
    2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd1, 2'd0,
    2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd1, 2'd0
  };

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [15:0] delta_ms;
  } req_t;

  typedef struct packed {
    logic [7:0]  midi_byte;
    logic [15:0] wait_ms;
    logic [3:0]  led_mask;
    logic [1:0]  onset_gate;
    logic [3:0]  bar_slot;
    logic [1:0]  layer;
    logic [15:0] beat_due_ms;
    logic        beat_due_valid;
  } res_t;

endpackage

/* rtl/mtg_ram.sv */
// ----------------------------------------------------------------------------
// mtg_ram
// Generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mtg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/midi_clock_tempo_generator.sv */
// ----------------------------------------------------------------------------
// midi_clock_tempo_generator
// MIDI clock generator locked to a tracked eighth-note period
//
// Requests enter on the in channel (valid/ready), one transfer per request:
// tick, sync delta, tempo delta, start, stop. Start, stop and ticks while
// running give one result transfer on the out channel; the rest give none.
// One request is worked on at a time; in_ready_o is high when the block is free.
//   start, stop : the result is registered, then loaded into the output register
//   tick        : out_valid_o rises after the slot correction read, sum and
//                 divide by reciprocal (ST_TK_RD, ST_TK_DIV, then ST_DONE)
//   sync, other : in_ready_o stays high, the next transfer can follow at once
//   tempo       : in_ready_o stays low through the period update, the limit
//                 step and the read-modify-write walk over latency_smooth
//                 slots of the slot correction ram, one slot per cycle
// The result sits in an output register, so a stalled receiver holds at most
// one finished result while the next request is already taken; the block then
// waits with that next result until the register frees up.
// Reset stops the clock, sets the period to 250 ms and marks every slot
// correction as zero through per-slot valid bits; start runs the clock and
// clears them the same way, leaving the period. The config port is always ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module midi_clock_tempo_generator
  import mtg_pkg::*;
#(
  parameter int BAR_SLOTS = BAR_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output res_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int SLOT_W = $clog2(BAR_SLOTS);
  localparam int EXT_W  = SLOT_W + 4;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_TK_RD   = 3'd1;
  localparam logic [2:0] ST_TK_DIV  = 3'd2;
  localparam logic [2:0] ST_TP_EP   = 3'd3;
  localparam logic [2:0] ST_TP_LIM  = 3'd4;
  localparam logic [2:0] ST_TP_LOOP = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  logic [2:0]               state_q, state_d;
  logic                     running_q, running_d;
  logic [3:0]               phase_q, phase_d;
  logic [15:0]              ep_q, ep_d;
  logic signed [15:0]       sync_q, sync_d;
  logic [15:0]              cp_q, cp_d;
  logic [SLOT_W-1:0]        pos_q, pos_d;
  logic [3:0]               led_q, led_d;
  logic [4:0]               amount_q;
  logic [3:0]               smooth_q;
  logic [BAR_SLOTS-1:0]     valid_q, valid_d;
  logic                     vld_rd_q;
  logic signed [15:0]       dlt_q, dlt_d;
  logic [15:0]              t_q, t_d;
  logic signed [16:0]       lim_q, lim_d;
  logic signed [5:0]        w_q, w_d;
  logic [3:0]               left_q, left_d;
  logic                     wr_pend_q, wr_pend_d;
  logic [SLOT_W-1:0]        raddr_q, raddr_d;
  logic [SLOT_W-1:0]        waddr_q, waddr_d;
  res_t                     res_q, res_d;
  logic                     out_valid_q, out_valid_d;
  res_t                     out_q, out_d;

  logic                     ram_we;
  logic [23:0]              ram_wdata;
  logic [SLOT_W-1:0]        ram_raddr;
  logic [23:0]              ram_rdata;

  logic signed [23:0]       corr;
  logic signed [24:0]       sum0;
  logic [15:0]              t0;
  logic [15:0]              half;
  logic signed [17:0]       sum6;
  logic [15:0]              t6;
  logic [16:0]              x0, x6;
  logic [15:0]              div_y;
  logic [31:0]              div_p;
  logic [15:0]              quo;
  logic signed [18:0]       d5, neg4ep;
  logic signed [17:0]       epsum;
  logic [15:0]              ep_sat;
  logic [17:0]              x4;
  logic [35:0]              lprod;
  logic signed [21:0]       mulw;
  logic signed [24:0]       v25;
  logic signed [23:0]       v24;
  logic signed [23:0]       lim24;
  logic [SLOT_W-1:0]        pos_inc;
  logic [EXT_W-1:0]         pos_ext, pos_inc_ext;
  logic                     pos_ok;
  logic                     due_out;
  logic                     done_go;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    if ({1'b0, s} == (SLOT_W+1)'(BAR_SLOTS - 1)) begin
      return '0;
    end
    return s + SLOT_W'(1);
  endfunction

  mtg_ram #(
    .WIDTH (24),
    .DEPTH (BAR_SLOTS)
  ) u_corr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_raddr   = (state_q == ST_TP_LOOP) ? raddr_q : pos_q;
  assign pos_inc     = slot_inc(pos_q);
  assign pos_ext     = EXT_W'(pos_q);
  assign pos_inc_ext = EXT_W'(pos_inc);
  assign pos_ok      = ({1'b0, pos_q} < (SLOT_W+1)'(BAR_SLOTS));

  // slot correction, zero where not written since reset, start or its last use
  assign corr = vld_rd_q ? $signed(ram_rdata) : 24'sd0;

  // eighth start: period plus slot correction, saturated
  assign sum0 = $signed({9'b0, ep_q}) + $signed({corr[23], corr});
  assign t0   = sum0[24] ? 16'd0 : ((|sum0[23:16]) ? 16'hFFFF : sum0[15:0]);

  // halfway: half period plus sync correction, saturated
  assign half = 16'(({1'b0, ep_q} + 17'd1) >> 1);
  assign sum6 = $signed({2'b0, half}) + $signed({{2{sync_q[15]}}, sync_q});
  assign t6   = sum6[17] ? 16'd0 : (sum6[16] ? 16'hFFFF : sum6[15:0]);

  // (t+6)/12 = ((t+6)>>2)/3 and (t+3)/6 = ((t+3)>>1)/3
  assign x0    = {1'b0, t_q} + 17'd6;
  assign x6    = {1'b0, t_q} + 17'd3;
  assign div_y = (phase_q == PH_EIGHTH) ? {1'b0, x0[16:2]} : x6[16:1];
  assign div_p = div_y * RECIP3;
  assign quo   = {1'b0, div_p[31:17]};

  // tempo period update
  assign d5     = ($signed({{3{dlt_q[15]}}, dlt_q}) <<< 2) + $signed({{3{dlt_q[15]}}, dlt_q});
  assign neg4ep = -$signed({1'b0, ep_q, 2'b00});
  assign epsum  = $signed({2'b0, ep_q}) + $signed({{2{dlt_q[15]}}, dlt_q});
  assign ep_sat = epsum[17] ? 16'd0 : (epsum[16] ? 16'hFFFF : epsum[15:0]);

  // floor(4*period/5)
  assign x4    = {ep_q, 2'b00};
  assign lprod = x4 * RECIP5;

  // weighted spread into one slot, saturated then floored at the limit
  assign mulw = dlt_q * w_q;
  assign v25  = $signed({corr[23], corr}) + $signed({{3{mulw[21]}}, mulw});
  always_comb begin
    if (!v25[24] && v25[23]) begin
      v24 = 24'sh7FFFFF;
    end else if (v25[24] && !v25[23]) begin
      v24 = -24'sh800000;
    end else begin
      v24 = v25[23:0];
    end
  end
  assign lim24     = $signed({{7{lim_q[16]}}, lim_q});
  assign ram_wdata = (v24 < lim24) ? 24'(lim24) : 24'(v24);

  always_comb begin
    logic [1:0]  gate;
    logic [15:0] due;
    logic        due_vld;
    logic [3:0]  bar;

    state_d     = state_q;
    running_d   = running_q;
    phase_d     = phase_q;
    ep_d        = ep_q;
    sync_d      = sync_q;
    cp_d        = cp_q;
    pos_d       = pos_q;
    led_d       = led_q;
    valid_d     = valid_q;
    dlt_d       = dlt_q;
    t_d         = t_q;
    lim_d       = lim_q;
    w_d         = w_q;
    left_d      = left_q;
    wr_pend_d   = wr_pend_q;
    raddr_d     = raddr_q;
    waddr_d     = waddr_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    gate        = GATE_NONE;
    due         = 16'd0;
    due_vld     = 1'b0;
    bar         = pos_ext[3:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dlt_d = in_data_i.delta_ms;
          unique case (in_data_i.req_type)
            REQ_TICK: begin
              if (running_q) begin
                state_d = ST_TK_RD;
              end
            end
            REQ_SYNC: begin
              sync_d = in_data_i.delta_ms;
            end
            REQ_TEMPO: begin
              state_d = ST_TP_EP;
            end
            REQ_START: begin
              running_d            = 1'b1;
              phase_d              = '0;
              sync_d               = '0;
              cp_d                 = '0;
              pos_d                = '0;
              led_d                = '0;
              valid_d              = '0;
              res_d.midi_byte      = MSG_START;
              res_d.wait_ms        = 16'd0;
              res_d.led_mask       = 4'd0;
              res_d.onset_gate     = GATE_ALLOW;
              res_d.bar_slot       = 4'd0;
              res_d.layer          = LAYER_TABLE[0];
              res_d.beat_due_ms    = 16'd0;
              res_d.beat_due_valid = 1'b0;
              state_d              = ST_DONE;
            end
            REQ_STOP: begin
              running_d            = 1'b0;
              led_d                = '0;
              res_d.midi_byte      = MSG_STOP;
              res_d.wait_ms        = 16'd0;
              res_d.led_mask       = 4'd0;
              res_d.onset_gate     = GATE_DISALLOW;
              res_d.bar_slot       = bar;
              res_d.layer          = LAYER_TABLE[bar];
              res_d.beat_due_ms    = 16'd0;
              res_d.beat_due_valid = 1'b0;
              state_d              = ST_DONE;
            end
            default: begin
            end
          endcase
        end
      end

      ST_TK_RD: begin
        if (phase_q == PH_EIGHTH) begin
          t_d            = t0;
          valid_d[pos_q] = 1'b0;
        end else begin
          t_d = t6;
        end
        state_d = ST_TK_DIV;
      end

      ST_TK_DIV: begin
        unique case (phase_q)
          PH_EIGHTH: begin
            cp_d = quo;
            if (!pos_ext[0]) begin
              led_d = led_q | (4'd1 << pos_ext[2:1]);
            end
          end
          PH_LED_OFF: begin
            led_d = '0;
          end
          PH_GATE_SYNC: begin
            gate = GATE_SYNC;
          end
          PH_HALF: begin
            cp_d    = quo;
            sync_d  = '0;
            pos_d   = pos_inc;
            due     = t_q;
            due_vld = 1'b1;
            bar     = pos_inc_ext[3:0];
          end
          PH_GATE_OPEN: begin
            gate = GATE_ALLOW;
          end
          default: begin
          end
        endcase
        phase_d = (phase_q == 4'(TICKS_PER_EIGHTH - 1)) ? 4'd0 : phase_q + 4'd1;
        res_d.midi_byte      = MSG_CLOCK;
        res_d.wait_ms        = cp_d;
        res_d.led_mask       = led_d;
        res_d.onset_gate     = gate;
        res_d.bar_slot       = bar;
        res_d.layer          = LAYER_TABLE[bar];
        res_d.beat_due_ms    = due;
        res_d.beat_due_valid = due_vld;
        state_d              = ST_DONE;
      end

      ST_TP_EP: begin
        if (d5 > neg4ep) begin
          ep_d = ep_sat;
        end
        state_d = ST_TP_LIM;
      end

      ST_TP_LIM: begin
        lim_d     = -$signed({1'b0, lprod[35:20]});
        w_d       = $signed({1'b0, amount_q});
        left_d    = smooth_q;
        raddr_d   = pos_inc;
        wr_pend_d = 1'b0;
        state_d   = ST_TP_LOOP;
      end

      ST_TP_LOOP: begin
        if (wr_pend_q) begin
          ram_we           = 1'b1;
          valid_d[waddr_q] = 1'b1;
          w_d              = w_q - 6'sd1;
        end
        if (left_q != 4'd0) begin
          waddr_d   = raddr_q;
          raddr_d   = slot_inc(raddr_q);
          left_d    = left_q - 4'd1;
          wr_pend_d = 1'b1;
        end else begin
          wr_pend_d = 1'b0;
          if (!wr_pend_q) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      running_q   <= 1'b0;
      phase_q     <= '0;
      ep_q        <= INIT_PERIOD;
      sync_q      <= '0;
      cp_q        <= '0;
      pos_q       <= '0;
      led_q       <= '0;
      amount_q    <= INIT_AMOUNT;
      smooth_q    <= INIT_SMOOTH;
      valid_q     <= '0;
      left_q      <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      phase_q     <= phase_d;
      ep_q        <= ep_d;
      sync_q      <= sync_d;
      cp_q        <= cp_d;
      pos_q       <= pos_d;
      led_q       <= led_d;
      valid_q     <= valid_d;
      left_q      <= left_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
      // period register writes are ignored; reset seeds the tracked period
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_LAT_AMOUNT: amount_q <= cfg_data_i[4:0];
          CFG_LAT_SMOOTH: smooth_q <= cfg_data_i[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vld_rd_q <= valid_q[ram_raddr];
    dlt_q    <= dlt_d;
    t_q      <= t_d;
    lim_q    <= lim_d;
    w_q      <= w_d;
    raddr_q  <= raddr_d;
    waddr_q  <= waddr_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign due_out = out_valid_o && out_data_o.beat_due_valid;
  assign done_go = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  `ASSERT_ALWAYS(a_phase_range, clk_i, rst_ni, phase_q < 4'(TICKS_PER_EIGHTH))
  `ASSERT_ALWAYS(a_pos_range, clk_i, rst_ni, pos_ok)
  `ASSERT_IMPL(a_ram_wr_loop, clk_i, rst_ni, ram_we, state_q == ST_TP_LOOP)
  `ASSERT_IMPL(a_due_on_clock, clk_i, rst_ni, due_out, out_data_o.midi_byte == MSG_CLOCK)
  `ASSERT_NEXT(a_done_loads, clk_i, rst_ni, done_go, out_valid_q && (state_q == ST_IDLE))

endmodule

/* tb/midi_clock_tempo_generator_tb.sv */
// ----------------------------------------------------------------------------
// midi_clock_tempo_generator_tb
// Self-checking bench for the midi clock tempo generator
//
// Requests go in over the valid/ready request channel and every message that
// comes out is checked field by field against a cycle-free model of the
// tracked period, the bar slot table and the tick phase. A short scripted
// sequence covers stop and start in both states, unused codes, the tick
// phases up to halfway and saturating corrections. Random traffic follows
// under several latency spread settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module midi_clock_tempo_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtg_pkg::*;

  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     SHOW_LIMIT  = 10;
  localparam longint ADJ_MAX     = 64'sd8388607;
  localparam longint ADJ_MIN     = -64'sd8388608;

  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  req;
    logic [15:0] delta;
    logic        fixed;
    res_t        want;
  } plan_row_t;

  localparam res_t STOP_AT_ZERO = '{MSG_STOP, 16'd0, 4'd0, GATE_DISALLOW, 4'd0,
                                    LAYER_TABLE[0], 16'd0, 1'b0};
  localparam res_t START_MSG    = '{MSG_START, 16'd0, 4'd0, GATE_ALLOW, 4'd0,
                                    LAYER_TABLE[0], 16'd0, 1'b0};
  localparam res_t FIRST_CLOCK  = '{MSG_CLOCK, 16'd21, 4'd1, GATE_NONE, 4'd0,
                                    LAYER_TABLE[0], 16'd0, 1'b0};

  localparam plan_row_t PLAN [22] = '{
    '{REQ_STOP,     16'h0000, 1'b1, STOP_AT_ZERO},
    '{REQ_TICK,     16'h0000, 1'b0, '0},
    '{REQ_SPARE_LO, 16'hFFFF, 1'b0, '0},
    '{REQ_SPARE_HI, 16'h8000, 1'b0, '0},
    '{REQ_START,    16'h0000, 1'b1, START_MSG},
    '{REQ_TICK,     16'h0000, 1'b1, FIRST_CLOCK},
    '{REQ_SYNC,     16'h8000, 1'b0, '0},
    '{REQ_TICK,     16'h0000, 1'b0, '0},
    '{REQ_TICK,     16'hFFFF, 1'b0, '0},
    '{REQ_TICK,     16'h0000, 1'b0, '0},
    '{REQ_TICK,     16'h0000, 1'b0, '0},
    '{REQ_TICK,     16'h0000, 1'b0, '0},
    '{REQ_TICK,     16'h0000, 1'b0, '0},
    '{REQ_TEMPO,    16'h7FFF, 1'b0, '0},
    '{REQ_TEMPO,    16'h7FFF, 1'b0, '0},
    '{REQ_SYNC,     16'h7FFF, 1'b0, '0},
    '{REQ_TEMPO,    16'h8000, 1'b0, '0},
    '{REQ_TEMPO,    16'h8000, 1'b0, '0},
    '{REQ_START,    16'h0000, 1'b1, START_MSG},
    '{REQ_STOP,     16'h0000, 1'b1, STOP_AT_ZERO},
    '{REQ_STOP,     16'h0000, 1'b1, STOP_AT_ZERO},
    '{REQ_START,    16'h0000, 1'b1, START_MSG}
  };

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  req_t        in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  res_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;

  // model of the generator
  logic [15:0]        init_period_reg = INIT_PERIOD;
  logic [4:0]         amount_reg      = INIT_AMOUNT;
  logic [3:0]         smooth_reg      = INIT_SMOOTH;
  bit                 clk_running     = 1'b0;
  int unsigned        tick_ph         = 0;
  logic [15:0]        eighth_ms       = INIT_PERIOD;
  logic signed [16:0] sync_ms         = '0;
  logic signed [23:0] slot_adj [BAR_SLOTS_DEF] = '{default: '0};
  logic [15:0]        tick_ms         = '0;
  int unsigned        slot            = 0;
  logic [3:0]         beat_leds       = '0;

  res_t midi_msgs_due [$];
  int   bad_msgs    = 0;
  int   msgs_seen   = 0;
  int   cycle_cnt   = 0;
  int   sink_hold   = 0;
  bit   quiet       = 1'b0;
  bit   held_fixed  = 1'b0;
  res_t held_want   = '0;

  midi_clock_tempo_generator dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [15:0] clamp_ms(input longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clock_next_msg(input req_t rq, output bit emits, output res_t msg);
    longint     d, tau, lim, w, v, t;
    int unsigned idx;
    logic [1:0] gate;
    logic [15:0] due;
    logic       due_v;
    emits = 1'b0;
    msg   = '0;
    gate  = GATE_NONE;
    due   = '0;
    due_v = 1'b0;
    d     = longint'($signed(rq.delta_ms));
    case (rq.req_type)
      REQ_SYNC: sync_ms = 17'(d);
      REQ_TEMPO: begin
        tau = longint'(eighth_ms);
        if (5 * d > -4 * tau) eighth_ms = clamp_ms(tau + d);
        lim = -((longint'(eighth_ms) * 4) / 5);
        w   = longint'(amount_reg);
        for (int j = 1; j <= int'(smooth_reg); j++) begin
          idx = (slot + j) % BAR_SLOTS_DEF;
          v   = longint'(slot_adj[idx]) + d * w;
          if (v > ADJ_MAX) v = ADJ_MAX;
          if (v < ADJ_MIN) v = ADJ_MIN;
          if (v < lim) v = lim;
          slot_adj[idx] = 24'(v);
          w--;
        end
      end
      REQ_START: begin
        clk_running = 1'b1;
        tick_ph     = 0;
        sync_ms     = '0;
        tick_ms     = '0;
        slot        = 0;
        beat_leds   = '0;
        foreach (slot_adj[i]) slot_adj[i] = '0;
        emits = 1'b1;
        msg   = '{MSG_START, 16'd0, 4'd0, GATE_ALLOW, 4'd0, LAYER_TABLE[0], 16'd0, 1'b0};
      end
      REQ_STOP: begin
        clk_running = 1'b0;
        beat_leds   = '0;
        emits = 1'b1;
        msg   = '{MSG_STOP, 16'd0, 4'd0, GATE_DISALLOW, 4'(slot), LAYER_TABLE[slot],
                  16'd0, 1'b0};
      end
      REQ_TICK: begin
        if (clk_running) begin
          case (tick_ph)
            PH_EIGHTH: begin
              t = longint'(clamp_ms(longint'(eighth_ms) + longint'(slot_adj[slot])));
              slot_adj[slot] = '0;
              tick_ms = 16'((t + 6) / 12);
              if ((slot % 8) % 2 == 0) beat_leds[(slot % 8) / 2] = 1'b1;
            end
            PH_LED_OFF: beat_leds = '0;
            PH_GATE_SYNC: gate = GATE_SYNC;
            PH_HALF: begin
              t = longint'(clamp_ms((longint'(eighth_ms) + 1) / 2 + longint'(sync_ms)));
              sync_ms = '0;
              tick_ms = 16'((t + 3) / 6);
              due     = 16'(t);
              due_v   = 1'b1;
              slot    = (slot + 1) % BAR_SLOTS_DEF;
            end
            PH_GATE_OPEN: gate = GATE_ALLOW;
            default: ;
          endcase
          emits = 1'b1;
          msg   = '{MSG_CLOCK, tick_ms, beat_leds, gate, 4'(slot), LAYER_TABLE[slot],
                    due, due_v};
          tick_ph = (tick_ph + 1) % TICKS_PER_EIGHTH;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_msg(input res_t got);
    res_t want;
    msgs_seen++;
    if (midi_msgs_due.size() == 0) begin
      bad_msgs++;
      if (bad_msgs <= SHOW_LIMIT)
        $display("msg %0d not expected: byte %0d wait %0d", msgs_seen, got.midi_byte,
                 got.wait_ms);
    end else begin
      want = midi_msgs_due.pop_front();
      if (got.midi_byte !== want.midi_byte || got.wait_ms !== want.wait_ms ||
          got.led_mask !== want.led_mask || got.onset_gate !== want.onset_gate ||
          got.bar_slot !== want.bar_slot || got.layer !== want.layer ||
          got.beat_due_ms !== want.beat_due_ms ||
          got.beat_due_valid !== want.beat_due_valid) begin
        bad_msgs++;
        if (bad_msgs <= SHOW_LIMIT) begin
          $write("msg %0d: expected byte %0d wait %0d led %h gate %0d slot %0d ",
                 msgs_seen, want.midi_byte, want.wait_ms, want.led_mask,
                 want.onset_gate, want.bar_slot);
          $write("layer %0d due %0d/%0d, got byte %0d wait %0d led %h gate %0d ",
                 want.layer, want.beat_due_ms, want.beat_due_valid, got.midi_byte,
                 got.wait_ms, got.led_mask, got.onset_gate);
          $display("slot %0d layer %0d due %0d/%0d", got.bar_slot, got.layer,
                   got.beat_due_ms, got.beat_due_valid);
        end
      end
    end
  endtask

  // transfers are sampled at the rising edge, before any register update
  always @(posedge clk_i) begin
    bit   emits;
    res_t msg;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_msg(out_data_o);
      if (in_valid_i && in_ready_o) begin
        clock_next_msg(in_data_i, emits, msg);
        if (emits) midi_msgs_due.push_back(held_fixed ? held_want : msg);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_INIT_PERIOD: init_period_reg = cfg_data_i;
          CFG_LAT_AMOUNT:  amount_reg = cfg_data_i[4:0];
          CFG_LAT_SMOOTH:  smooth_reg = cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (sink_hold != 0) begin
      sink_hold--;
    end else if ($urandom_range(0, 99) < 60) begin
      out_ready_i <= 1'b1;
      sink_hold = $urandom_range(0, 8);
    end else begin
      out_ready_i <= 1'b0;
      sink_hold = pick_gap();
    end
  end

  task automatic send_req(input logic [2:0] kind, input logic [15:0] delta,
                          input bit fixed, input res_t want);
    int gap;
    held_fixed = fixed;
    held_want  = want;
    in_data_i  <= '{kind, delta};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain_msgs();
    in_valid_i <= 1'b0;
    while (midi_msgs_due.size() != 0) @(negedge clk_i);
    repeat (32) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_spread(input logic [15:0] period, input logic [4:0] amount,
                            input logic [3:0] smooth);
    drain_msgs();
    write_reg(CFG_INIT_PERIOD, period);
    write_reg(CFG_LAT_AMOUNT, {11'd0, amount});
    write_reg(CFG_LAT_SMOOTH, {12'd0, smooth});
    cfg_valid_i <= 1'b0;
  endtask

  // ignored codes and ticks while stopped do not count toward the total
  task automatic run_traffic(input int count);
    int          done;
    int          r;
    logic [2:0]  kind;
    logic [15:0] delta;
    bit          counts;
    done = 0;
    while (done < count) begin
      if (done % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      r     = $urandom_range(0, 99);
      delta = 16'($urandom);
      if (r < 70) begin
        kind = REQ_TICK;
      end else if (r < 78) begin
        kind = REQ_SYNC;
        if ($urandom_range(0, 3) != 0) delta = 16'($urandom_range(0, 200)) - 16'd100;
      end else if (r < 87) begin
        kind = REQ_TEMPO;
        if ($urandom_range(0, 4) != 0) delta = 16'($urandom_range(0, 60)) - 16'd30;
      end else if (r < 93) begin
        kind = REQ_START;
      end else if (r < 96) begin
        kind = REQ_STOP;
      end else begin
        kind = 3'(REQ_STOP + $urandom_range(1, 3));
      end
      counts = (kind <= REQ_STOP) && !(kind == REQ_TICK && !clk_running);
      send_req(kind, delta, 1'b0, '0);
      if (counts) done++;
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (PLAN[i]) send_req(PLAN[i].req, PLAN[i].delta, PLAN[i].fixed, PLAN[i].want);
    run_traffic(150);
    drain_msgs();
    run_traffic(100);
    set_spread(16'hFFFF, 5'd31, 4'd15);
    run_traffic(250);
    set_spread(16'd1, 5'd0, 4'd0);
    run_traffic(250);
    set_spread(16'd250, 5'd31, 4'd0);
    run_traffic(250);
    set_spread(16'd500, 5'd0, 4'd15);
    run_traffic(200);
    set_spread(16'($urandom), 5'($urandom), 4'($urandom));
    run_traffic(250);
    drain_msgs();
    repeat (8) @(negedge clk_i);
    bad_msgs += midi_msgs_due.size();
    if (bad_msgs == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
